// ----- design/prcv_pkg.sv -----
package prcv_pkg;

    localparam int RECORD_BYTES   = 4096;
    localparam int CRC_END_OFFSET = 4080;
    localparam int CRC_START      = 8;

    localparam int OFFSET_W = $clog2(RECORD_BYTES);
    localparam int TAIL_W   = 12;
    localparam int CMP_W    = ((OFFSET_W > TAIL_W) ? OFFSET_W : TAIL_W) + 1;
    localparam int END_W    = 17;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] TAIL_EXPECTED = 32'hDEAD_BEEF;
    localparam logic [31:0] TAIL_RESET    = 32'd4080;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MAGIC = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_OFFSET  = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MAGIC = 2'd1,
        STATUS_BAD_TAIL  = 2'd2,
        STATUS_BAD_CRC   = 2'd3
    } status_t;

    // One byte of the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[lane*8 +: 8] = b;
        return r;
    endfunction

endpackage

// ----- design/prcv_if.sv -----
interface prcv_item_if;
    import prcv_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       record_start;

    modport source (output valid, output data_byte, output record_start, input ready);
    modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface prcv_result_if;
    import prcv_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] computed_crc;

    modport source (output valid, output status, output computed_crc, input ready);
    modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

interface prcv_cfg_if;
    import prcv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/param_record_crc32_validator.sv -----
// Validates a fixed-size parameter record streamed one byte per transfer in address order.
// The magic word (offset 0), stored CRC (offset 4) and tail marker (offset tail_offset) are
// gathered little-endian, and a reflected CRC-32 runs over offsets 8 up to CRC_END_OFFSET.
// One byte is taken every clock cycle; the byte-wide CRC network and the offset compares sit
// between the record state registers, so the rate is one byte per cycle. A result transfer
// carries the status and computed CRC and appears in the cycle after the last record byte is
// taken. Only a last byte waits, and only while the previous result is still held
// downstream; all other bytes are accepted regardless of the result side. Configuration
// writes are always accepted and should be made between records.
module param_record_crc32_validator
(
    input  logic           clk,
    input  logic           rst_n,
    prcv_item_if.sink      item,
    prcv_result_if.source  result,
    prcv_cfg_if.sink       cfg
);
    import prcv_pkg::*;

    logic [31:0]         header_magic_reg;
    logic [TAIL_W-1:0]   tail_offset_reg;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [31:0]         crc_reg, crc_next;
    logic [31:0]         magic_reg, magic_next;
    logic [31:0]         stored_reg, stored_next;
    logic [31:0]         tail_reg, tail_next;

    logic                res_valid_reg;
    status_t             status_reg, status_next;
    logic [31:0]         res_crc_reg, res_crc_next;

    logic [OFFSET_W-1:0] base_off;
    logic [31:0]         base_crc;
    logic [31:0]         upd_crc;
    logic [31:0]         upd_magic;
    logic [31:0]         upd_stored;
    logic [31:0]         upd_tail;
    logic [31:0]         final_crc;
    logic [CMP_W-1:0]    tail_diff;
    logic                in_crc_range;
    logic                is_last;
    logic                item_fire;

    // The offset never reaches RECORD_BYTES, and a start byte is offset 0, which is never last.
    assign is_last   = !item.record_start && (offset_reg == OFFSET_W'(RECORD_BYTES - 1));
    assign item.ready = !res_valid_reg || result.ready || !is_last;
    assign item_fire = item.valid && item.ready;
    assign cfg.ready = 1'b1;

    assign result.valid        = res_valid_reg;
    assign result.status       = status_reg;
    assign result.computed_crc = res_crc_reg;

    always_comb
    begin
        base_off = item.record_start ? '0 : offset_reg;
        base_crc = item.record_start ? CRC_INIT : crc_reg;

        upd_magic  = item.record_start ? 32'd0 : magic_reg;
        upd_stored = item.record_start ? 32'd0 : stored_reg;
        upd_tail   = item.record_start ? 32'd0 : tail_reg;

        if (base_off < OFFSET_W'(4))
        begin
            upd_magic = put_byte(upd_magic, base_off[1:0], item.data_byte);
        end
        if ((base_off >= OFFSET_W'(4)) && (base_off < OFFSET_W'(8)))
        begin
            upd_stored = put_byte(upd_stored, base_off[1:0], item.data_byte);
        end

        tail_diff = CMP_W'(base_off) - CMP_W'(tail_offset_reg);
        if ((CMP_W'(base_off) >= CMP_W'(tail_offset_reg)) && (tail_diff < CMP_W'(4)))
        begin
            upd_tail = put_byte(upd_tail, tail_diff[1:0], item.data_byte);
        end

        in_crc_range = (END_W'(base_off) >= END_W'(CRC_START))
                    && (END_W'(base_off) <  END_W'(CRC_END_OFFSET));
        upd_crc   = in_crc_range ? crc32_byte(base_crc, item.data_byte) : base_crc;
        final_crc = upd_crc ^ CRC_INIT;

        priority if (upd_magic != header_magic_reg)
        begin
            status_next = STATUS_BAD_MAGIC;
        end
        else if (upd_tail != TAIL_EXPECTED)
        begin
            status_next = STATUS_BAD_TAIL;
        end
        else if (final_crc != upd_stored)
        begin
            status_next = STATUS_BAD_CRC;
        end
        else
        begin
            status_next = STATUS_OK;
        end
        res_crc_next = final_crc;

        if (is_last)
        begin
            offset_next = '0;
            crc_next    = CRC_INIT;
            magic_next  = 32'd0;
            stored_next = 32'd0;
            tail_next   = 32'd0;
        end
        else
        begin
            offset_next = base_off + OFFSET_W'(1);
            crc_next    = upd_crc;
            magic_next  = upd_magic;
            stored_next = upd_stored;
            tail_next   = upd_tail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_magic_reg <= 32'd0;
            tail_offset_reg  <= TAIL_RESET[TAIL_W-1:0];
            offset_reg       <= '0;
            crc_reg          <= CRC_INIT;
            magic_reg        <= 32'd0;
            stored_reg       <= 32'd0;
            tail_reg         <= 32'd0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_HEADER_MAGIC)
                begin
                    header_magic_reg <= cfg.data;
                end
                else if (cfg.index == REG_TAIL_OFFSET)
                begin
                    tail_offset_reg <= cfg.data[TAIL_W-1:0];
                end
            end

            if (item_fire)
            begin
                offset_reg <= offset_next;
                crc_reg    <= crc_next;
                magic_reg  <= magic_next;
                stored_reg <= stored_next;
                tail_reg   <= tail_next;
            end

            if (item_fire && is_last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && is_last)
        begin
            status_reg  <= status_next;
            res_crc_reg <= res_crc_next;
        end
    end

    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFFSET_W'(RECORD_BYTES - 1))
        else $error("record offset ran past the last byte");

    a_offset_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && !is_last) |=> (offset_reg == $past(base_off) + OFFSET_W'(1)))
        else $error("record offset did not advance by one byte");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && is_last) |=> (res_valid_reg && (offset_reg == '0) && (crc_reg == CRC_INIT)
                                    && (magic_reg == 32'd0) && (tail_reg == 32'd0)))
        else $error("last byte did not raise a result and restart the record");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready && is_last) |-> !item.ready)
        else $error("last byte accepted while a result was still held");

    a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid_reg && !(item_fire && is_last)) |=> !res_valid_reg)
        else $error("result raised without a last record byte");

endmodule

// ----- tb/param_record_crc32_validator_tb.sv -----
`timescale 1ns / 1ps

module param_record_crc32_validator_tb;
    import prcv_pkg::*;

    localparam int CYCLE_LIMIT       = 3000000;
    localparam int LONG_STALL_CYCLES = 10000;
    localparam int SETTLE_CYCLES     = 4;
    localparam int RECORDS_PER_PHASE = 4;
    localparam int SETTING_PHASES    = 8;
    localparam int REG_COUNT         = 2;

    typedef struct packed {
        status_t     status;
        logic [31:0] crc;
    } verdict_t;

    typedef enum int {REC_GOOD, REC_BAD_MAGIC, REC_BAD_TAIL, REC_BAD_CRC} record_kind_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // Tracks the record the block is parsing and queues the verdict it must give.
    class record_verdict_board;
        logic [31:0] magic_reg;
        logic [11:0] tail_reg;
        int unsigned offset;
        logic [31:0] crc_run;
        logic [31:0] magic_word;
        logic [31:0] stored_word;
        logic [31:0] tail_word;
        verdict_t    awaited[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned status_hits[4];

        function new();
            magic_reg = '0;
            tail_reg  = TAIL_RESET[11:0];
            failures  = 0;
            checked   = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
            restart();
        endfunction

        function void restart();
            offset      = 0;
            crc_run     = CRC_INIT;
            magic_word  = '0;
            stored_word = '0;
            tail_word   = '0;
        endfunction

        // The data bit is folded in at the moment it reaches the bottom of the register.
        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            for (int i = 0; i < 8; i++)
                c = (c >> 1) ^ ({32{c[0] ^ b[i]}} & CRC_POLY);
            return c;
        endfunction

        static function logic [31:0] merge_lane(logic [31:0] w, int unsigned off,
                                                int unsigned base, logic [7:0] b);
            if (off >= base && off - base < 4)
                w[(off - base) * 8 +: 8] = b;
            return w;
        endfunction

        function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_HEADER_MAGIC: magic_reg = value;
                REG_TAIL_OFFSET:  tail_reg  = value[11:0];
                default:          ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            verdict_t    v;
            logic [31:0] final_crc;
            if (start)
                restart();
            magic_word  = merge_lane(magic_word, offset, 0, b);
            stored_word = merge_lane(stored_word, offset, 4, b);
            tail_word   = merge_lane(tail_word, offset, tail_reg, b);
            if (offset >= CRC_START && offset < CRC_END_OFFSET)
                crc_run = crc_step(crc_run, b);
            if (offset + 1 >= RECORD_BYTES)
            begin
                final_crc = crc_run ^ CRC_INIT;
                if (magic_word != magic_reg)
                    v.status = STATUS_BAD_MAGIC;
                else if (tail_word != TAIL_EXPECTED)
                    v.status = STATUS_BAD_TAIL;
                else if (final_crc != stored_word)
                    v.status = STATUS_BAD_CRC;
                else
                    v.status = STATUS_OK;
                v.crc = final_crc;
                awaited.push_back(v);
                restart();
            end
            else
                offset++;
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] crc);
            verdict_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d crc %h",
                         $time, st, crc);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (!$isunknown(st))
                status_hits[st]++;
            if (st !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d (%s), actual %0d",
                         $time, want.status, want.status.name(), st);
                failures++;
            end
            if (crc !== want.crc)
            begin
                $display("%0t: computed_crc mismatch: expected %h, actual %h",
                         $time, want.crc, crc);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    prcv_item_if   item_ch();
    prcv_result_if result_ch();
    prcv_cfg_if    cfg_ch();

    param_record_crc32_validator dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    record_verdict_board ledger = new();

    logic [7:0]  record_image [RECORD_BYTES];
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    bit          long_stall_request = 1'b0;
    int          long_stall_left    = 0;
    bit          at_boundary        = 1'b1;
    int unsigned bytes_sent         = 0;
    int unsigned records_sent       = 0;
    int unsigned fragments_sent     = 0;
    int unsigned reg_writes         = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: run exceeded %0d cycles with %0d results outstanding",
                 $time, CYCLE_LIMIT, ledger.awaited.size());
        $display("Verification failed");
        $finish;
    end

    // Result side: ready changes on the falling edge; a long hold-off is counted here.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_request)
            begin
                long_stall_left    = LONG_STALL_CYCLES;
                long_stall_request = 1'b0;
            end
            if (long_stall_left > 0)
            begin
                long_stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            ledger.check_result(result_ch.status, result_ch.computed_crc);
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                sender_idle_pct    = 54;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 54;
            end
            IDLE_BOTH:
            begin
                sender_idle_pct    = 10;
                receiver_stall_pct = 10;
            end
            default:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic s);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.data_byte    <= b;
        item_ch.record_start <= s;
        do
            @(posedge clk);
        while (!item_ch.ready);
        ledger.note_byte(b, s);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        ledger.apply_reg(idx, value);
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic enter_setting(input logic [31:0] magic, input logic [11:0] tail);
        hold_until_drained();
        load_reg(REG_HEADER_MAGIC, magic);
        load_reg(REG_TAIL_OFFSET, {20'd0, tail});
        if ($urandom_range(0, 1) == 1)
            load_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, (1 << CFG_INDEX_W) - 1)),
                     $urandom());
    endtask

    // Lays out a record that passes every check the tail setting allows, then damages it as the kind asks.
    function automatic void build_record(input record_kind_t kind, input fill_t fill);
        logic [31:0] crc;
        int unsigned pos;
        for (int i = 0; i < RECORD_BYTES; i++)
        begin
            case (fill)
                FILL_ZERO: record_image[i] = 8'h00;
                FILL_ONES: record_image[i] = 8'hFF;
                default:   record_image[i] = 8'($urandom());
            endcase
        end
        for (int i = 0; i < 4; i++)
            record_image[i] = ledger.magic_reg[i * 8 +: 8];
        for (int i = 0; i < 4; i++)
            if (ledger.tail_reg + i < RECORD_BYTES)
                record_image[ledger.tail_reg + i] = TAIL_EXPECTED[i * 8 +: 8];
        crc = CRC_INIT;
        for (int i = CRC_START; i < CRC_END_OFFSET && i < RECORD_BYTES; i++)
            crc = record_verdict_board::crc_step(crc, record_image[i]);
        crc = crc ^ CRC_INIT;
        for (int i = 0; i < 4; i++)
            record_image[4 + i] = crc[i * 8 +: 8];
        case (kind)
            REC_BAD_MAGIC: pos = $urandom_range(0, 3);
            REC_BAD_TAIL:
            begin
                pos = ledger.tail_reg + $urandom_range(0, 3);
                if (pos >= RECORD_BYTES)
                    pos = ledger.tail_reg;
            end
            REC_BAD_CRC:   pos = $urandom_range(4, CRC_END_OFFSET - 1);
            default:       pos = RECORD_BYTES;
        endcase
        if (pos < RECORD_BYTES)
            record_image[pos] ^= 8'(1 << $urandom_range(0, 7));
    endfunction

    task automatic send_record(input record_kind_t kind, input fill_t fill, input bit mark);
        build_record(kind, fill);
        for (int i = 0; i < RECORD_BYTES; i++)
            push_byte(record_image[i], (i == 0) && mark);
        records_sent++;
        at_boundary = 1'b1;
    endtask

    // A record abandoned part way, with the odd restart inside it.
    task automatic send_fragment();
        int len;
        len = $urandom_range(1, 400);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom()), (i == 0) || ($urandom_range(0, 63) == 0));
        fragments_sent++;
        at_boundary = 1'b0;
    endtask

    task automatic run_records(input int count);
        int           roll;
        record_kind_t kind;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_fragment();
            roll = $urandom_range(0, 99);
            if (roll < 55)
                kind = REC_GOOD;
            else if (roll < 70)
                kind = REC_BAD_MAGIC;
            else if (roll < 85)
                kind = REC_BAD_TAIL;
            else
                kind = REC_BAD_CRC;
            send_record(kind, FILL_RANDOM, !at_boundary || ($urandom_range(0, 2) != 0));
            if ($urandom_range(0, 4) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        logic [31:0] magic;
        logic [11:0] tail;

        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.data_byte    = 8'h00;
        item_ch.record_start = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_HEADER_MAGIC;
        cfg_ch.data          = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed records at the reset settings.
        set_idling(IDLE_NONE);
        load_reg(CFG_INDEX_W'(REG_COUNT), $urandom());
        send_record(REC_GOOD, FILL_RANDOM, 1'b1);
        send_record(REC_GOOD, FILL_ONES, 1'b0);
        send_record(REC_BAD_CRC, FILL_ZERO, 1'b1);
        send_record(REC_BAD_MAGIC, FILL_RANDOM, 1'b1);
        send_record(REC_BAD_TAIL, FILL_RANDOM, 1'b0);
        send_fragment();
        send_record(REC_GOOD, FILL_RANDOM, 1'b1);

        // Results held back long enough that a second last byte must wait at the input.
        hold_until_drained();
        long_stall_request = 1'b1;
        for (int k = 0; k < 3; k++)
            send_record(REC_GOOD, FILL_RANDOM, 1'b1);

        for (int phase = 0; phase < SETTING_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    magic = 32'hFFFF_FFFF;
                    tail  = 12'd0;
                end
                1:
                begin
                    magic = 32'h0000_0000;
                    tail  = 12'hFFF;
                end
                2:
                begin
                    magic = $urandom();
                    tail  = 12'd4;
                end
                3:
                begin
                    magic = $urandom();
                    tail  = 12'd4092;
                end
                4:
                begin
                    magic = $urandom();
                    tail  = 12'($urandom_range(CRC_START, CRC_END_OFFSET - 1));
                end
                5:
                begin
                    magic = $urandom();
                    tail  = TAIL_RESET[11:0];
                end
                6:
                begin
                    magic = 32'hFFFF_FFFF;
                    tail  = 12'd4093;
                end
                default:
                begin
                    magic = $urandom();
                    tail  = 12'($urandom());
                end
            endcase
            enter_setting(magic, tail);
            set_idling(idle_mode_t'(phase % 4));
            run_records(RECORDS_PER_PHASE);
        end

        hold_until_drained();
        repeat (16) @(posedge clk);

        if (ledger.awaited.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, ledger.awaited.size());
            ledger.failures++;
        end
        $display("Streamed %0d bytes: %0d full records and %0d abandoned fragments, %0d writes.",
                 bytes_sent, records_sent, fragments_sent, reg_writes);
        $display("Checked %0d results: ok %0d, bad magic %0d, bad tail %0d, bad crc %0d.",
                 ledger.checked, ledger.status_hits[STATUS_OK],
                 ledger.status_hits[STATUS_BAD_MAGIC], ledger.status_hits[STATUS_BAD_TAIL],
                 ledger.status_hits[STATUS_BAD_CRC]);
        if (ledger.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
